>>> design/btc_pkg.sv
`timescale 1ns / 1ps

package btc_pkg;

  // Ticks-per-second compare value after reset
  localparam logic [15:0] TpsReset = 16'd10000;

  // Input item kinds
  typedef enum logic {
    ACT_TICK  = 1'b0,
    ACT_DIGIT = 1'b1
  } btc_action_e;

  // Time-setting positions, visited in order
  typedef enum logic [1:0] {
    POS_HOUR_TENS    = 2'd0,
    POS_HOUR_UNITS   = 2'd1,
    POS_MINUTE_TENS  = 2'd2,
    POS_MINUTE_UNITS = 2'd3
  } btc_pos_e;

  // Six BCD digits of the time
  typedef struct packed {
    logic [1:0] hour_tens;
    logic [3:0] hour_units;
    logic [2:0] minute_tens;
    logic [3:0] minute_units;
    logic [2:0] second_tens;
    logic [3:0] second_units;
  } btc_time_t;

  // One result item
  typedef struct packed {
    btc_time_t  time_of_day;
    logic [1:0] set_position;
    logic       digit_accepted;
    logic       second_elapsed;
  } btc_result_t;

  // Exclusive upper bound for a digit entered at a position
  function automatic logic [3:0] btc_digit_limit(btc_pos_e pos);
    logic [3:0] lim;
    case (pos)
      POS_HOUR_TENS:    lim = 4'd3;
      POS_HOUR_UNITS:   lim = 4'd10;
      POS_MINUTE_TENS:  lim = 4'd6;
      POS_MINUTE_UNITS: lim = 4'd10;
      default:          lim = 4'd0;
    endcase
    return lim;
  endfunction

endpackage

>>> design/btc_core.sv
`timescale 1ns / 1ps

module btc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic                action_i,
  input  logic [3:0]          digit_i,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  output btc_pkg::btc_result_t result_o
);
  import btc_pkg::*;

  // One second forward with carry through minutes and hours
  function automatic btc_time_t advance_second(btc_time_t t);
    btc_time_t n;
    n = t;
    if (t.second_units < 4'd9) begin
      n.second_units = t.second_units + 4'd1;
    end else begin
      n.second_units = '0;
      if (t.second_tens < 3'd5) begin
        n.second_tens = t.second_tens + 3'd1;
      end else begin
        n.second_tens = '0;
        if (t.minute_units < 4'd9) begin
          n.minute_units = t.minute_units + 4'd1;
        end else begin
          n.minute_units = '0;
          if (t.minute_tens < 3'd5) begin
            n.minute_tens = t.minute_tens + 3'd1;
          end else begin
            n.minute_tens = '0;
            // hours 24..29 are held as they are
            if (t.hour_tens < 2'd2) begin
              if (t.hour_units < 4'd9) begin
                n.hour_units = t.hour_units + 4'd1;
              end else begin
                n.hour_units = '0;
                n.hour_tens  = t.hour_tens + 2'd1;
              end
            end else if (t.hour_tens == 2'd2 && t.hour_units < 4'd3) begin
              n.hour_units = t.hour_units + 4'd1;
            end else if (t.hour_tens == 2'd2 && t.hour_units == 4'd3) begin
              n.hour_units = '0;
              n.hour_tens  = '0;
            end
          end
        end
      end
    end
    return n;
  endfunction

  logic [15:0] tps_q;
  logic [15:0] prescale_q, prescale_d;
  btc_time_t   time_q, time_d;
  btc_pos_e    pos_q, pos_d;
  logic [15:0] cnt_inc;
  logic        accepted, elapsed;

  // Next state for the item at the input
  always_comb begin
    cnt_inc    = prescale_q + 16'd1;
    prescale_d = prescale_q;
    time_d     = time_q;
    pos_d      = pos_q;
    accepted   = 1'b0;
    elapsed    = 1'b0;
    if (btc_action_e'(action_i) == ACT_TICK) begin
      prescale_d = cnt_inc;
      if (cnt_inc >= tps_q) begin
        prescale_d = '0;
        elapsed    = 1'b1;
        time_d     = advance_second(time_q);
      end
    end else if (digit_i < btc_digit_limit(pos_q)) begin
      case (pos_q)
        POS_HOUR_TENS:    time_d.hour_tens    = digit_i[1:0];
        POS_HOUR_UNITS:   time_d.hour_units   = digit_i;
        POS_MINUTE_TENS:  time_d.minute_tens  = digit_i[2:0];
        POS_MINUTE_UNITS: time_d.minute_units = digit_i;
        default:          time_d = time_q;
      endcase
      pos_d    = btc_pos_e'(pos_q + 2'd1);
      accepted = 1'b1;
    end
  end

  // Result shows the state after the item
  assign result_o = '{time_of_day:    time_d,
                      set_position:   pos_d,
                      digit_accepted: accepted,
                      second_elapsed: elapsed};

  // State and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q      <= TpsReset;
      prescale_q <= '0;
      time_q     <= '0;
      pos_q      <= POS_HOUR_TENS;
    end else begin
      if (cfg_we_i) begin
        tps_q <= cfg_wdata_i;
      end
      if (push_i) begin
        prescale_q <= prescale_d;
        time_q     <= time_d;
        pos_q      <= pos_d;
      end
    end
  end

endmodule

>>> design/btc_skid.sv
`timescale 1ns / 1ps

module btc_skid (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  btc_pkg::btc_result_t data_i,
  output logic                 ready_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output btc_pkg::btc_result_t data_o
);
  import btc_pkg::*;

  btc_result_t out_q, skid_q;
  logic        out_valid_q, skid_valid_q;

  // Upstream only sees whether the spare slot is taken
  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (ready_i) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || ready_i) begin
      out_valid_q <= push_i;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (ready_i) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || ready_i) begin
      out_q <= data_i;
    end else if (push_i) begin
      skid_q <= data_i;
    end
  end

endmodule

>>> design/bcd_time_of_day_clock.sv
`timescale 1ns / 1ps
// An accepted item's result is registered in the output register, or in the spare slot while the output is stalled.
// Throughput: one item per cycle while the spare slot is free; the time update is a single registered pass.
// A two-entry output buffer keeps the input open for one stalled result.
// Reset (async, active low): time 00:00:00, prescaler 0, entry at hour tens,
// ticks_per_second 10000, no result pending.
module bcd_time_of_day_clock (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [3:0]  digit_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  hour_tens_o,
  output logic [3:0]  hour_units_o,
  output logic [2:0]  minute_tens_o,
  output logic [3:0]  minute_units_o,
  output logic [2:0]  second_tens_o,
  output logic [3:0]  second_units_o,
  output logic [1:0]  set_position_o,
  output logic        digit_accepted_o,
  output logic        second_elapsed_o
);
  import btc_pkg::*;

  logic        push;
  btc_result_t next_res, out_res;

  assign push = in_valid_i && in_ready_o;

  // Time keeping and digit entry
  btc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .action_i   (action_i),
    .digit_i    (digit_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .result_o   (next_res)
  );

  // Result register with spare slot
  btc_skid u_skid (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (next_res),
    .ready_o(in_ready_o),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .data_o (out_res)
  );

  assign hour_tens_o      = out_res.time_of_day.hour_tens;
  assign hour_units_o     = out_res.time_of_day.hour_units;
  assign minute_tens_o    = out_res.time_of_day.minute_tens;
  assign minute_units_o   = out_res.time_of_day.minute_units;
  assign second_tens_o    = out_res.time_of_day.second_tens;
  assign second_units_o   = out_res.time_of_day.second_units;
  assign set_position_o   = out_res.set_position;
  assign digit_accepted_o = out_res.digit_accepted;
  assign second_elapsed_o = out_res.second_elapsed;

  // A transfer in always leaves a result pending
  a_push_then_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> out_valid_o)
    else $error("accepted item produced no pending result");

  // Input only closes while a result is held
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // A result is either a tick or a digit outcome, never both
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(digit_accepted_o && second_elapsed_o))
    else $error("digit and second flags both set");

  // Seconds stay within BCD 00..59
  a_seconds_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (second_units_o <= 4'd9 && second_tens_o <= 3'd5))
    else $error("seconds digits out of range");

endmodule

>>> tb/btc_time_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the BCD clock, keeps its own copy of the time,
// and compares every result transfer against the oldest expected reading.
module btc_time_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        action_i,
  input  logic [3:0]  digit_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  hour_tens_i,
  input  logic [3:0]  hour_units_i,
  input  logic [2:0]  minute_tens_i,
  input  logic [3:0]  minute_units_i,
  input  logic [2:0]  second_tens_i,
  input  logic [3:0]  second_units_i,
  input  logic [1:0]  set_position_i,
  input  logic        digit_accepted_i,
  input  logic        second_elapsed_i,
  output int          fail_count_o,
  output int          pending_o
);
  import btc_pkg::*;

  // Shadow state of the clock
  logic [15:0] tick_goal;
  logic [15:0] tick_count;
  logic [3:0]  clock_digits [6];
  btc_pos_e    entry_pos;

  btc_result_t expected_time_q [$];

  // Carry one second through seconds, minutes and hours
  task automatic bump_second();
    if (clock_digits[5] < 4'd9) begin
      clock_digits[5]++;
    end else begin
      clock_digits[5] = 4'd0;
      if (clock_digits[4] < 4'd5) begin
        clock_digits[4]++;
      end else begin
        clock_digits[4] = 4'd0;
        if (clock_digits[3] < 4'd9) begin
          clock_digits[3]++;
        end else begin
          clock_digits[3] = 4'd0;
          if (clock_digits[2] < 4'd5) begin
            clock_digits[2]++;
          end else begin
            clock_digits[2] = 4'd0;
            // hours 24..29 fall through every arm and stay put
            if (clock_digits[0] < 4'd2 && clock_digits[1] < 4'd9) begin
              clock_digits[1]++;
            end else if (clock_digits[0] < 4'd2 && clock_digits[1] == 4'd9) begin
              clock_digits[1] = 4'd0;
              clock_digits[0]++;
            end else if (clock_digits[0] == 4'd2 && clock_digits[1] < 4'd3) begin
              clock_digits[1]++;
            end else if (clock_digits[0] == 4'd2 && clock_digits[1] == 4'd3) begin
              clock_digits[0] = 4'd0;
              clock_digits[1] = 4'd0;
            end
          end
        end
      end
    end
  endtask

  // Apply one input item and return the reading it should produce
  task automatic compute_next_time(input logic act, input logic [3:0] dig,
                                   output btc_result_t reading);
    logic [3:0] lim;
    logic [1:0] nxt;
    reading = '0;
    if (btc_action_e'(act) == ACT_TICK) begin
      tick_count = tick_count + 16'd1;
      if (tick_count >= tick_goal) begin
        tick_count = 16'd0;
        reading.second_elapsed = 1'b1;
        bump_second();
      end
    end else begin
      case (entry_pos)
        POS_HOUR_TENS:    lim = 4'd3;
        POS_HOUR_UNITS:   lim = 4'd10;
        POS_MINUTE_TENS:  lim = 4'd6;
        default:          lim = 4'd10;
      endcase
      if (dig < lim) begin
        clock_digits[{1'b0, entry_pos}] = dig;
        nxt = entry_pos + 2'd1;
        entry_pos = btc_pos_e'(nxt);
        reading.digit_accepted = 1'b1;
      end
    end
    reading.time_of_day.hour_tens    = clock_digits[0][1:0];
    reading.time_of_day.hour_units   = clock_digits[1];
    reading.time_of_day.minute_tens  = clock_digits[2][2:0];
    reading.time_of_day.minute_units = clock_digits[3];
    reading.time_of_day.second_tens  = clock_digits[4][2:0];
    reading.time_of_day.second_units = clock_digits[5];
    reading.set_position             = entry_pos;
  endtask

  task automatic note_failure(input string what, input btc_result_t want,
                              input btc_result_t got);
    if (fail_count_o < 10) begin
      $display({"%0t: %s: exp %0d%0d:%0d%0d:%0d%0d pos %0d acc %0b sec %0b,",
                " got %0d%0d:%0d%0d:%0d%0d pos %0d acc %0b sec %0b"},
               $realtime, what,
               want.time_of_day.hour_tens, want.time_of_day.hour_units,
               want.time_of_day.minute_tens, want.time_of_day.minute_units,
               want.time_of_day.second_tens, want.time_of_day.second_units,
               want.set_position, want.digit_accepted, want.second_elapsed,
               got.time_of_day.hour_tens, got.time_of_day.hour_units,
               got.time_of_day.minute_tens, got.time_of_day.minute_units,
               got.time_of_day.second_tens, got.time_of_day.second_units,
               got.set_position, got.digit_accepted, got.second_elapsed);
    end
    fail_count_o++;
  endtask

  // Result check first, then config and input; a result never belongs
  // to an item accepted at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    btc_result_t got;
    btc_result_t want;
    logic        bad;
    if (!rst_ni) begin
      tick_goal    = TpsReset;
      tick_count   = 16'd0;
      for (int i = 0; i < 6; i++) clock_digits[i] = 4'd0;
      entry_pos    = POS_HOUR_TENS;
      expected_time_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.time_of_day.hour_tens    = hour_tens_i;
        got.time_of_day.hour_units   = hour_units_i;
        got.time_of_day.minute_tens  = minute_tens_i;
        got.time_of_day.minute_units = minute_units_i;
        got.time_of_day.second_tens  = second_tens_i;
        got.time_of_day.second_units = second_units_i;
        got.set_position             = set_position_i;
        got.digit_accepted           = digit_accepted_i;
        got.second_elapsed           = second_elapsed_i;
        if (expected_time_q.size() == 0) begin
          note_failure("unexpected result", '0, got);
        end else begin
          want = expected_time_q.pop_front();
          bad = 1'b0;
          bad |= (got.time_of_day.hour_tens    !== want.time_of_day.hour_tens);
          bad |= (got.time_of_day.hour_units   !== want.time_of_day.hour_units);
          bad |= (got.time_of_day.minute_tens  !== want.time_of_day.minute_tens);
          bad |= (got.time_of_day.minute_units !== want.time_of_day.minute_units);
          bad |= (got.time_of_day.second_tens  !== want.time_of_day.second_tens);
          bad |= (got.time_of_day.second_units !== want.time_of_day.second_units);
          bad |= (got.set_position             !== want.set_position);
          bad |= (got.digit_accepted           !== want.digit_accepted);
          bad |= (got.second_elapsed           !== want.second_elapsed);
          if (bad) note_failure("mismatch", want, got);
        end
      end
      if (cfg_we_i) tick_goal = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        compute_next_time(action_i, digit_i, want);
        expected_time_q.push_back(want);
      end
      pending_o = expected_time_q.size();
    end
  end

endmodule

>>> tb/tb_bcd_time_of_day_clock.sv
`timescale 1ns / 1ps

module tb_bcd_time_of_day_clock;
  import btc_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int SegItems   = 90;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        action_i = ACT_TICK;
  logic [3:0]  digit_i = 4'd0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = 16'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  hour_tens_o;
  logic [3:0]  hour_units_o;
  logic [2:0]  minute_tens_o;
  logic [3:0]  minute_units_o;
  logic [2:0]  second_tens_o;
  logic [3:0]  second_units_o;
  logic [1:0]  set_position_o;
  logic        digit_accepted_o;
  logic        second_elapsed_o;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int sent_in_seg;
  btc_pos_e entry_pos = POS_HOUR_TENS;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  bcd_time_of_day_clock u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .digit_i         (digit_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hour_tens_o     (hour_tens_o),
    .hour_units_o    (hour_units_o),
    .minute_tens_o   (minute_tens_o),
    .minute_units_o  (minute_units_o),
    .second_tens_o   (second_tens_o),
    .second_units_o  (second_units_o),
    .set_position_o  (set_position_o),
    .digit_accepted_o(digit_accepted_o),
    .second_elapsed_o(second_elapsed_o)
  );

  btc_time_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .action_i        (action_i),
    .digit_i         (digit_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hour_tens_i     (hour_tens_o),
    .hour_units_i    (hour_units_o),
    .minute_tens_i   (minute_tens_o),
    .minute_units_i  (minute_units_o),
    .second_tens_i   (second_tens_o),
    .second_units_i  (second_units_o),
    .set_position_i  (set_position_o),
    .digit_accepted_i(digit_accepted_o),
    .second_elapsed_i(second_elapsed_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // Receiver backpressure
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // One input transfer; entered and left at a falling edge
  task automatic send_item(input btc_action_e act, input logic [3:0] dig);
    logic [1:0] nxt;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    digit_i    <= dig;
    do @(posedge clk_i); while (!in_ready_o);
    // track the entry position so set sequences start at hour tens
    if (act == ACT_DIGIT && dig < btc_digit_limit(entry_pos)) begin
      nxt = entry_pos + 2'd1;
      entry_pos = btc_pos_e'(nxt);
    end
    sent_in_seg++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_tps(input logic [15:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic tick_run(input int n);
    repeat (n) send_item(ACT_TICK, 4'($urandom_range(15)));
  endtask

  // Accepted time entry, at times with hours 24..29, often landing near a minute or day rollover
  task automatic enter_clock_setting();
    logic [3:0] ht;
    logic [3:0] hu;
    while (entry_pos != POS_HOUR_TENS) send_item(ACT_DIGIT, 4'd0);
    ht = 4'($urandom_range(2));
    if (ht == 4'd2) hu = ($urandom_range(3) == 0) ? 4'($urandom_range(9, 4))
                                                 : 4'($urandom_range(3));
    else hu = 4'($urandom_range(9));
    send_item(ACT_DIGIT, ht);
    send_item(ACT_DIGIT, hu);
    send_item(ACT_DIGIT, $urandom_range(1) ? 4'd5 : 4'($urandom_range(5)));
    send_item(ACT_DIGIT, $urandom_range(1) ? 4'd9 : 4'($urandom_range(9)));
  endtask

  task automatic pick_tps(input int phase, input int seg);
    logic [15:0] v;
    case ($urandom_range(7))
      0, 1:    v = 16'd1;
      2:       v = 16'd2;
      3:       v = 16'd3;
      4:       v = 16'($urandom_range(20, 4));
      5:       v = 16'hFFFF;
      6:       v = TpsReset;
      default: v = 16'($urandom_range(65535, 1));
    endcase
    if (seg == 0) v = 16'd1;
    if (seg == 4 && phase == 2) v = 16'hFFFF;
    write_tps(v);
  endtask

  initial begin
    int r;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reset rate, rejected key codes, every position, hour 29
    send_idle_pct = 19;
    recv_idle_pct = 59;
    send_item(ACT_TICK, 4'd0);
    send_item(ACT_DIGIT, 4'd15);
    send_item(ACT_DIGIT, 4'd11);
    send_item(ACT_DIGIT, 4'd12);
    send_item(ACT_DIGIT, 4'd10);
    send_item(ACT_DIGIT, 4'd13);
    send_item(ACT_DIGIT, 4'd14);
    send_item(ACT_DIGIT, 4'd3);
    send_item(ACT_DIGIT, 4'd2);
    send_item(ACT_DIGIT, 4'd10);
    send_item(ACT_DIGIT, 4'd9);
    send_item(ACT_DIGIT, 4'd6);
    send_item(ACT_DIGIT, 4'd5);
    send_item(ACT_DIGIT, 4'd15);
    send_item(ACT_DIGIT, 4'd9);
    // slowest rate, then drop the rate below the running count
    write_tps(16'hFFFF);
    tick_run(3);
    write_tps(16'd2);
    tick_run(3);
    // fastest rate
    write_tps(16'd1);
    tick_run(2);
    send_item(ACT_DIGIT, 4'd0);
    send_item(ACT_DIGIT, 4'd0);

    // Random: three idle modes, several rate settings each
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 19; recv_idle_pct = 59; end
        1:       begin send_idle_pct = 59; recv_idle_pct = 19; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      for (int seg = 0; seg < 5; seg++) begin
        pick_tps(phase, seg);
        sent_in_seg = 0;
        while (sent_in_seg < SegItems) begin
          r = $urandom_range(99);
          if (r < 55) begin
            enter_clock_setting();
            tick_run($urandom_range(70, 1));
          end else if (r < 85) begin
            tick_run($urandom_range(40, 1));
          end else begin
            repeat ($urandom_range(4, 1))
              send_item(btc_action_e'($urandom_range(1)), 4'($urandom_range(15)));
          end
        end
      end
    end

    // Drain and give the verdict
    wait_idle();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
